// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, same-cycle implication, reset-gated
`define ITRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Concurrent check, next-cycle implication, reset-gated
`define ITRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/itrt_pkg.sv -----
package itrt_pkg;

  localparam int unsigned MAX_DIGITS = 64;
  localparam int unsigned MAX_RADIX  = 16;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DADDR_W = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W   = DADDR_W + 1;
  localparam int unsigned BYTES_W = $clog2(VALUE_W / 8);
  localparam int unsigned CIDX_W  = 2;

  localparam logic [RADIX_W-1:0] RESET_RADIX      = 5'd10;
  localparam logic [VALUE_W-1:0] RESET_ALPHA_LOW  = 64'h3736353433323130;
  localparam logic [VALUE_W-1:0] RESET_ALPHA_HIGH = 64'h6665646362613938;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_RADIX    = 2'd0,
    CFG_ALPHA_LO = 2'd1,
    CFG_ALPHA_HI = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               en;
    logic [DADDR_W-1:0] addr;
    logic [DIGIT_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic               en;
    logic [DADDR_W-1:0] addr;
  } store_rd_t;

  // Clamp the radix register into the supported range
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_W'(2)) begin
      res = RADIX_W'(2);
    end else if (r > RADIX_W'(MAX_RADIX)) begin
      res = RADIX_W'(MAX_RADIX);
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d,
                                                 input logic [VALUE_W-1:0] lo,
                                                 input logic [VALUE_W-1:0] hi);
    logic [5:0] sh;
    sh = {d[2:0], 3'b000};
    return d[3] ? hi[sh +: CHAR_W] : lo[sh +: CHAR_W];
  endfunction

endpackage

// ----- rtl/itrt_div_step.sv -----
module itrt_div_step import itrt_pkg::*; (
  input  logic [DIGIT_W-1:0] rem_i,
  input  logic [7:0]         byte_i,
  input  logic [RADIX_W-1:0] radix_i,
  output logic [7:0]         quot_o,
  output logic [DIGIT_W-1:0] rem_o
);

  // Eight restoring steps over one byte; the partial remainder stays below the radix
  always_comb begin
    logic [RADIX_W-1:0] part;
    part = {1'b0, rem_i};
    quot_o = '0;
    for (int i = 7; i >= 0; i--) begin
      part = {part[RADIX_W-2:0], byte_i[i]};
      if (part >= radix_i) begin
        part = part - radix_i;
        quot_o[i] = 1'b1;
      end
    end
    rem_o = part[DIGIT_W-1:0];
  end

endmodule

// ----- rtl/itrt_digit_store.sv -----
module itrt_digit_store import itrt_pkg::*; (
  input  logic               clk_i,
  input  store_wr_t          wr_i,
  input  store_rd_t          rd_i,
  output logic [DIGIT_W-1:0] rd_data_o
);

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_o <= mem[rd_i.addr];
    end
  end

endmodule

// ----- rtl/integer_to_radix_text_unit.sv -----
// Converts a 64-bit value, signed or unsigned, to digit characters in a radix of
// 2 to 16, most significant digit first, one output word per digit; the last
// word is flagged and a minus sign rides as the negative flag on every word.
// Characters come from the two alphabet registers. Each digit is found by
// the shared byte-wide long-division step, over all 64 bits, 8 bits a cycle;
// then the digits are read back from the digit store one a cycle while the
// output is not stalled. The input is not ready while a value is divided
// and its digits are read out. Configuration writes are accepted every cycle
// and must only be made while the block is idle with all words delivered.
module integer_to_radix_text_unit import itrt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               is_signed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHAR_W-1:0]  character_o,
  output logic               negative_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CIDX_W-1:0]  cfg_index_i,
  input  logic [VALUE_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [RADIX_W-1:0] radix_q;
  logic [VALUE_W-1:0] alpha_lo_q, alpha_hi_q;

  logic [VALUE_W-1:0] work_q, work_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [BYTES_W-1:0] byte_cnt_q;
  logic [CNT_W-1:0]   n_q, rd_left_q, rd_idx;
  logic               neg_q, in_neg;
  logic               fetch_pend_q, fetch_last_q;

  logic               out_valid_q, out_neg_q, out_last_q;
  logic [CHAR_W-1:0]  out_char_q;

  logic [7:0]         quot;
  logic [DIGIT_W-1:0] step_rem, rd_data;
  logic               accept, digit_done, div_finish, load, issue;
  store_wr_t          wr;
  store_rd_t          rd;

  itrt_div_step u_div_step (
    .rem_i   (rem_q),
    .byte_i  (work_q[VALUE_W-1 -: 8]),
    .radix_i (eff_radix(radix_q)),
    .quot_o  (quot),
    .rem_o   (step_rem)
  );

  itrt_digit_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  assign cfg_ready_o = 1'b1;
  assign in_neg      = is_signed_i & value_i[VALUE_W-1];
  assign rd_idx      = rd_left_q - CNT_W'(1);

  // Sequencer: next state and control
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    digit_done = 1'b0;
    div_finish = 1'b0;
    issue      = 1'b0;
    work_d     = {work_q[VALUE_W-9:0], quot};
    rem_d      = step_rem;
    load       = fetch_pend_q & (~out_valid_q | out_ready_i);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        digit_done = (byte_cnt_q == '1);
        if (digit_done) begin
          rem_d = '0;
          if ((work_d == '0) || (n_q == CNT_W'(MAX_DIGITS - 1))) begin
            div_finish = 1'b1;
            state_d    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        issue = (rd_left_q != '0) & (~fetch_pend_q | load);
        if ((rd_left_q == '0) && (!fetch_pend_q || load)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign wr.en   = digit_done;
  assign wr.addr = n_q[DADDR_W-1:0];
  assign wr.data = step_rem;
  assign rd.en   = issue;
  assign rd.addr = rd_idx[DADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RESET_RADIX;
      alpha_lo_q <= RESET_ALPHA_LOW;
      alpha_hi_q <= RESET_ALPHA_HIGH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RADIX:    radix_q    <= cfg_data_i[RADIX_W-1:0];
        CFG_ALPHA_LO: alpha_lo_q <= cfg_data_i;
        CFG_ALPHA_HI: alpha_hi_q <= cfg_data_i;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q   <= '0;
      n_q          <= '0;
      rd_left_q    <= '0;
      fetch_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        byte_cnt_q <= '0;
        n_q        <= '0;
      end else if (state_q == ST_DIVIDE) begin
        byte_cnt_q <= byte_cnt_q + BYTES_W'(1);
        if (digit_done) begin
          n_q <= n_q + CNT_W'(1);
        end
      end
      if (div_finish) begin
        rd_left_q <= n_q + CNT_W'(1);
      end else if (issue) begin
        rd_left_q <= rd_idx;
      end
      if (issue) begin
        fetch_pend_q <= 1'b1;
      end else if (load) begin
        fetch_pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_q <= in_neg ? (VALUE_W'(0) - value_i) : value_i;
      rem_q  <= '0;
      neg_q  <= in_neg;
    end else if (state_q == ST_DIVIDE) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
    if (issue) begin
      fetch_last_q <= (rd_left_q == CNT_W'(1));
    end
    if (load) begin
      out_char_q <= glyph_of(rd_data, alpha_lo_q, alpha_hi_q);
      out_neg_q  <= neg_q;
      out_last_q <= fetch_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = out_char_q;
  assign negative_o  = out_neg_q;
  assign last_o      = out_last_q;

endmodule

// ----- rtl/itrt_checker.sv -----
`include "assert_macros.svh"

module itrt_checker import itrt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CHAR_W-1:0] character_o,
  input logic              negative_o,
  input logic              last_o,
  input logic              cfg_ready_o
);

  `ITRT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(character_o), "output word dropped or changed while stalled")
  `ITRT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input still ready while converting")
  `ITRT_ASSERT_NXT(a_gap_after_last, clk_i, rst_ni, out_valid_o && out_ready_i && last_o, !out_valid_o, "word follows the final digit at once")
  `ITRT_ASSERT_NXT(a_sign_steady, clk_i, rst_ni, out_valid_o && out_ready_i && !last_o, !out_valid_o || $stable(negative_o), "sign flag changed within one value")
  `ITRT_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o, "configuration port not ready")

endmodule

bind integer_to_radix_text_unit itrt_checker u_itrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_o (character_o),
  .negative_o  (negative_o),
  .last_o      (last_o),
  .cfg_ready_o (cfg_ready_o)
);
